### hdl/goi_pkg.sv
// ----------------------------------------------------------------------------
// goi_pkg
// Shared types and codes of the obstacle inflation block.
// ----------------------------------------------------------------------------
`default_nettype none

package goi_pkg;

  localparam logic [1:0] MODE_TABLE = 2'd0;
  localparam logic [1:0] MODE_CELL  = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CELL_RADIUS = 2'd2;

  localparam int CFG_AW = 4;

  localparam logic [7:0] GRID_WIDTH_RST  = 8'd128;
  localparam logic [7:0] GRID_HEIGHT_RST = 8'd128;

  localparam logic signed [7:0] OCCUPIED = 8'sd100;

  typedef struct packed {
    logic [1:0]        mode;
    logic [6:0]        cell_x;
    logic [6:0]        cell_y;
    logic signed [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] cell_value;
    logic              run_done;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RDOUT,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_APP_RD,
    OP_APP_WR,
    OP_BIN_START,
    OP_BIN_HEAD,
    OP_ENT_RD,
    OP_ENT_VIS,
    OP_ENT_UPD,
    OP_NB_RD,
    OP_NB_CHK,
    OP_NB_SQ,
    OP_NB_NEXT,
    OP_ENT_NEXT,
    OP_ENT_ADV,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic run_trivial;
    logic seed;
    logic scan_last;
    logic pool_full;
    logic bin_filled;
    logic last_bin;
    logic vis;
    logic nb_ok;
    logic nb_reject;
    logic nb_last;
    logic sq_busy;
    logic push_ok;
    logic tail_hit;
  } sts_t;

endpackage

`default_nettype wire

### hdl/goi_isqrt.sv
// ----------------------------------------------------------------------------
// goi_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module goi_isqrt #(
  parameter int NW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] n_in,
  output logic               busy,
  output logic [NW-1:0]      root
);

  localparam int TOPE = 2 * ((NW - 1) / 2);
  localparam logic [NW-1:0] TOPB = NW'(64'd1 << TOPE);

  logic [NW-1:0] rem_r, res_r, bit_r;
  logic [NW:0]   trial;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign busy  = (bit_r != '0);
  assign root  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (start) begin
      bit_r <= TOPB;
      rem_r <= n_in;
      res_r <= '0;
    end else if (busy) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r <= rem_r - NW'(trial);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

`default_nettype wire

### hdl/goi_dpath.sv
// ----------------------------------------------------------------------------
// goi_dpath
// Grid, cost table, visit marks, bin lists and wavefront arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module goi_dpath #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int MAX_RADIUS  = 31,
  parameter int QUEUE_DEPTH = 131072
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire goi_pkg::cmd_t       cmd,
  output goi_pkg::sts_t            sts,
  input  wire goi_pkg::in_item_t   in_data,
  input  wire logic [7:0]          cfg_width,
  input  wire logic [7:0]          cfg_height,
  input  wire logic [4:0]          cfg_radius,
  output goi_pkg::out_item_t       out_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int NCELL = MAX_WIDTH * MAX_HEIGHT;
  localparam int GA    = $clog2(NCELL);
  localparam int TS    = MAX_RADIUS + 2;
  localparam int NCOST = TS * TS;
  localparam int CA    = $clog2(NCOST);
  localparam int NBINS = 2 * TS;
  localparam int BW    = $clog2(NBINS);
  localparam int NBW   = $clog2(NBINS + 1);
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int D2W   = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
  localparam int NW    = D2W + 2;
  localparam int EW    = $clog2(QUEUE_DEPTH);
  localparam int PW    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTW  = 2 * XW + 2 * YW;

  goi_pkg::op_t op;
  assign op = cmd.op;

  // effective configuration
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [RDW-1:0] eff_r;
  assign eff_w = (32'(cfg_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_width);
  assign eff_h = (32'(cfg_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_height);
  assign eff_r = (32'(cfg_radius) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(cfg_radius);

  logic [WW-1:0]  w_r;
  logic [HW-1:0]  h_r;
  logic [RDW-1:0] r_r;
  logic [D2W-1:0] r2_r;
  logic [NBW-1:0] nbins_r;

  // item decode
  logic          cell_in, tab_in, rd_in_r;
  logic [GA-1:0] cell_addr;
  logic [CA-1:0] tab_addr;
  assign cell_in = (32'(in_data.cell_x) < 32'(eff_w)) && (32'(in_data.cell_y) < 32'(eff_h));
  assign tab_in  = (32'(in_data.cell_x) < TS) && (32'(in_data.cell_y) < TS);
  assign cell_addr = GA'(32'(in_data.cell_y) * MAX_WIDTH + 32'(in_data.cell_x));
  assign tab_addr  = CA'(32'(in_data.cell_y) * TS + 32'(in_data.cell_x));

  // seed scan
  logic [XW-1:0] scx_r;
  logic [YW-1:0] scy_r;
  logic [GA-1:0] scan_addr;
  logic          scan_last;
  assign scan_addr = GA'(32'(scy_r) * MAX_WIDTH + 32'(scx_r));
  assign scan_last = (32'(scx_r) == MAX_WIDTH - 1) && (32'(scy_r) == MAX_HEIGHT - 1);

  // memory read data
  logic [7:0]      grid_q;
  logic            vis_q;
  logic [6:0]      cost_q;
  logic [ENTW-1:0] pay_q;
  logic [EW-1:0]   next_q, head_q, tail_q;

  // entry decode
  logic [XW-1:0] px, psx, pax;
  logic [YW-1:0] py, psy, pay;
  logic [GA-1:0] ent_addr;
  logic [CA-1:0] cost_addr;
  assign {px, py, psx, psy} = pay_q;
  assign pax = (px > psx) ? px - psx : psx - px;
  assign pay = (py > psy) ? py - psy : psy - py;
  assign ent_addr  = GA'(32'(py) * MAX_WIDTH + 32'(px));
  assign cost_addr = CA'(32'(pay) * TS + 32'(pax));

  logic [XW-1:0] cx_r, sx_r, nx_r, adx_r;
  logic [YW-1:0] cy_r, sy_r, ny_r, ady_r;
  logic [GA-1:0] ent_idx_r;
  logic [1:0]    nb_r;

  // neighbor select
  logic [XW-1:0] nx, nadx;
  logic [YW-1:0] ny, nady;
  logic          nb_ok;
  logic [GA-1:0] nb_addr;
  always_comb begin
    nx    = cx_r;
    ny    = cy_r;
    nb_ok = 1'b0;
    unique case (nb_r)
      2'd0: begin
        nx    = cx_r - XW'(1);
        nb_ok = (cx_r != '0);
      end
      2'd1: begin
        nx    = cx_r + XW'(1);
        nb_ok = (32'(cx_r) + 1 < 32'(w_r));
      end
      2'd2: begin
        ny    = cy_r - YW'(1);
        nb_ok = (cy_r != '0);
      end
      default: begin
        ny    = cy_r + YW'(1);
        nb_ok = (32'(cy_r) + 1 < 32'(h_r));
      end
    endcase
  end
  assign nadx    = (nx > sx_r) ? nx - sx_r : sx_r - nx;
  assign nady    = (ny > sy_r) ? ny - sy_r : sy_r - ny;
  assign nb_addr = GA'(32'(ny) * MAX_WIDTH + 32'(nx));

  // distance and bin
  logic [RDW-1:0] ax, ay;
  logic [D2W-1:0] d2, d2_r;
  logic           nb_reject, sq_start, sq_busy, push_ok;
  logic [NW-1:0]  sq_root;
  logic [BW-1:0]  b_r;
  assign ax = RDW'(adx_r);
  assign ay = RDW'(ady_r);
  assign d2 = D2W'(32'(ax) * 32'(ax) + 32'(ay) * 32'(ay));
  assign nb_reject = vis_q || (32'(adx_r) > 32'(r_r)) || (32'(ady_r) > 32'(r_r));
  assign sq_start  = (op == goi_pkg::OP_NB_CHK) && !nb_reject;
  assign push_ok   = !sq_busy && (d2_r <= r2_r) && (32'(sq_root) >= 32'(b_r))
                     && (32'(sq_root) < 32'(nbins_r));

  goi_isqrt #(.NW(NW)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .n_in  ({d2, 2'b00}),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  // append request
  logic [BW-1:0] app_bin_r;
  logic [XW-1:0] app_x_r, app_sx_r;
  logic [YW-1:0] app_y_r, app_sy_r;
  logic [PW-1:0] pool_r;
  logic [EW-1:0] e_r;
  logic          filled_r [NBINS];
  logic          pool_full, tail_hit, last_bin;
  assign pool_full = (32'(pool_r) >= QUEUE_DEPTH);
  assign tail_hit  = (e_r == tail_q);
  assign last_bin  = (32'(b_r) == 32'(nbins_r) - 1);

  // memories
  logic [7:0]      grid_mem [NCELL];
  logic            vis_mem  [NCELL];
  logic [6:0]      cost_mem [NCOST];
  logic [ENTW-1:0] pay_mem  [QUEUE_DEPTH];
  logic [EW-1:0]   next_mem [QUEUE_DEPTH];
  logic [EW-1:0]   head_mem [NBINS];
  logic [EW-1:0]   tail_mem [NBINS];

  logic          grid_we, vis_we, vis_wd, upd;
  logic [GA-1:0] grid_wa, grid_ra, vis_wa, vis_ra;
  logic [7:0]    grid_wd;
  logic [BW-1:0] tail_ra;
  logic          app_wr;

  assign upd    = !grid_q[7] && ({1'b0, cost_q} > grid_q);
  assign app_wr = (op == goi_pkg::OP_APP_WR);

  always_comb begin
    grid_we = 1'b0;
    grid_wa = cell_addr;
    grid_wd = in_data.value;
    vis_we  = 1'b0;
    vis_wa  = scan_addr;
    vis_wd  = 1'b0;
    if (op == goi_pkg::OP_ACCEPT) begin
      grid_we = (in_data.mode == goi_pkg::MODE_CELL) && cell_in;
    end else if (op == goi_pkg::OP_SCAN_RD) begin
      vis_we = 1'b1;
    end else if (op == goi_pkg::OP_ENT_UPD) begin
      grid_we = !vis_q && upd;
      grid_wa = ent_idx_r;
      grid_wd = {1'b0, cost_q};
      vis_we  = !vis_q;
      vis_wa  = ent_idx_r;
      vis_wd  = 1'b1;
    end
  end

  assign grid_ra = (op == goi_pkg::OP_ENT_VIS) ? ent_addr :
                   (op == goi_pkg::OP_SCAN_RD) ? scan_addr : cell_addr;
  assign vis_ra  = (op == goi_pkg::OP_NB_RD) ? nb_addr : ent_addr;
  assign tail_ra = (op == goi_pkg::OP_APP_RD) ? app_bin_r : b_r;

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_wa] <= grid_wd;
    grid_q <= grid_mem[grid_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (op == goi_pkg::OP_ACCEPT && in_data.mode == goi_pkg::MODE_TABLE && tab_in) begin
      cost_mem[tab_addr] <= in_data.value[6:0];
    end
    cost_q <= cost_mem[cost_addr];
  end

  always_ff @(posedge clk) begin
    if (app_wr) pay_mem[EW'(pool_r)] <= {app_x_r, app_y_r, app_sx_r, app_sy_r};
    pay_q <= pay_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (app_wr && filled_r[app_bin_r]) next_mem[tail_q] <= EW'(pool_r);
    next_q <= next_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (app_wr && !filled_r[app_bin_r]) head_mem[app_bin_r] <= EW'(pool_r);
    head_q <= head_mem[b_r];
  end

  always_ff @(posedge clk) begin
    if (app_wr) tail_mem[app_bin_r] <= EW'(pool_r);
    tail_q <= tail_mem[tail_ra];
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= '0;
      b_r    <= '0;
      nb_r   <= '0;
      scx_r  <= '0;
      scy_r  <= '0;
      for (int i = 0; i < NBINS; i++) filled_r[i] <= 1'b0;
    end else begin
      unique case (op)
        goi_pkg::OP_ACCEPT: begin
          if (in_data.mode == goi_pkg::MODE_RUN) begin
            pool_r <= '0;
            b_r    <= '0;
            scx_r  <= '0;
            scy_r  <= '0;
            for (int i = 0; i < NBINS; i++) filled_r[i] <= 1'b0;
          end
        end
        goi_pkg::OP_SCAN_CHK: begin
          if (32'(scx_r) == MAX_WIDTH - 1) begin
            scx_r <= '0;
            scy_r <= scy_r + YW'(1);
          end else begin
            scx_r <= scx_r + XW'(1);
          end
        end
        goi_pkg::OP_APP_WR: begin
          filled_r[app_bin_r] <= 1'b1;
          pool_r              <= pool_r + PW'(1);
        end
        goi_pkg::OP_BIN_START: begin
          if (!filled_r[b_r]) b_r <= b_r + BW'(1);
        end
        goi_pkg::OP_ENT_UPD: nb_r <= '0;
        goi_pkg::OP_NB_NEXT: nb_r <= nb_r + 2'd1;
        goi_pkg::OP_ENT_ADV: begin
          if (tail_hit) b_r <= b_r + BW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      goi_pkg::OP_ACCEPT: begin
        rd_in_r <= cell_in;
        w_r     <= eff_w;
        h_r     <= eff_h;
        r_r     <= eff_r;
        r2_r    <= D2W'(32'(eff_r) * 32'(eff_r));
        nbins_r <= NBW'(2 * (32'(eff_r) + 2));
      end
      goi_pkg::OP_SCAN_CHK: begin
        app_bin_r <= '0;
        app_x_r   <= scx_r;
        app_y_r   <= scy_r;
        app_sx_r  <= scx_r;
        app_sy_r  <= scy_r;
      end
      goi_pkg::OP_BIN_HEAD: e_r <= head_q;
      goi_pkg::OP_ENT_VIS: begin
        cx_r      <= px;
        cy_r      <= py;
        sx_r      <= psx;
        sy_r      <= psy;
        ent_idx_r <= ent_addr;
      end
      goi_pkg::OP_NB_RD: begin
        nx_r  <= nx;
        ny_r  <= ny;
        adx_r <= nadx;
        ady_r <= nady;
      end
      goi_pkg::OP_NB_CHK: d2_r <= d2;
      goi_pkg::OP_NB_SQ: begin
        app_bin_r <= BW'(sq_root);
        app_x_r   <= nx_r;
        app_y_r   <= ny_r;
        app_sx_r  <= sx_r;
        app_sy_r  <= sy_r;
      end
      goi_pkg::OP_ENT_ADV: begin
        if (!tail_hit) e_r <= next_q;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data.cell_value <= (op == goi_pkg::OP_RDOUT && rd_in_r) ? grid_q : '0;
      out_data.run_done   <= (op == goi_pkg::OP_FIN);
    end
  end

  always_comb begin
    sts.run_trivial = (eff_r == '0) || (eff_w == '0) || (eff_h == '0);
    sts.seed        = (32'(scx_r) < 32'(w_r)) && (32'(scy_r) < 32'(h_r))
                      && ($signed(grid_q) >= goi_pkg::OCCUPIED);
    sts.scan_last   = scan_last;
    sts.pool_full   = pool_full;
    sts.bin_filled  = filled_r[b_r];
    sts.last_bin    = last_bin;
    sts.vis         = vis_q;
    sts.nb_ok       = nb_ok;
    sts.nb_reject   = nb_reject;
    sts.nb_last     = (nb_r == 2'd3);
    sts.sq_busy     = sq_busy;
    sts.push_ok     = push_ok;
    sts.tail_hit    = tail_hit;
  end

endmodule

`default_nettype wire

### hdl/goi_ctrl.sv
// ----------------------------------------------------------------------------
// goi_ctrl
// Sequencer for item handling, seed scan and wavefront expansion.
// ----------------------------------------------------------------------------
`default_nettype none

module goi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_mode,
  output logic               out_valid,
  input  wire logic          out_stall,
  output goi_pkg::cmd_t      cmd,
  input  wire goi_pkg::sts_t sts
);

  typedef enum logic [17:0] {
    S_IDLE      = 18'h00001,
    S_RDOUT     = 18'h00002,
    S_SCAN_RD   = 18'h00004,
    S_SCAN_CHK  = 18'h00008,
    S_APP_RD    = 18'h00010,
    S_APP_WR    = 18'h00020,
    S_BIN_START = 18'h00040,
    S_BIN_HEAD  = 18'h00080,
    S_ENT_RD    = 18'h00100,
    S_ENT_VIS   = 18'h00200,
    S_ENT_UPD   = 18'h00400,
    S_NB_RD     = 18'h00800,
    S_NB_CHK    = 18'h01000,
    S_NB_SQ     = 18'h02000,
    S_NB_NEXT   = 18'h04000,
    S_ENT_NEXT  = 18'h08000,
    S_ENT_ADV   = 18'h10000,
    S_FIN       = 18'h20000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt, acc;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cmd.op     = goi_pkg::OP_NONE;
    cmd.out_ld = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.op = goi_pkg::OP_ACCEPT;
          priority if (in_mode == goi_pkg::MODE_RUN) begin
            state_nxt = sts.run_trivial ? S_FIN : S_SCAN_RD;
          end else if (in_mode == goi_pkg::MODE_READ) begin
            state_nxt = S_RDOUT;
          end else begin
            cmd.out_ld = 1'b1;
          end
        end
      end
      S_RDOUT: begin
        cmd.op     = goi_pkg::OP_RDOUT;
        cmd.out_ld = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd.op    = goi_pkg::OP_SCAN_RD;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.op = goi_pkg::OP_SCAN_CHK;
        if (sts.seed) begin
          ret_nxt   = sts.scan_last ? S_BIN_START : S_SCAN_RD;
          state_nxt = S_APP_RD;
        end else begin
          state_nxt = sts.scan_last ? S_BIN_START : S_SCAN_RD;
        end
      end
      S_APP_RD: begin
        cmd.op    = goi_pkg::OP_APP_RD;
        state_nxt = sts.pool_full ? ret_r : S_APP_WR;
      end
      S_APP_WR: begin
        cmd.op    = goi_pkg::OP_APP_WR;
        state_nxt = ret_r;
      end
      S_BIN_START: begin
        cmd.op = goi_pkg::OP_BIN_START;
        priority if (sts.bin_filled) state_nxt = S_BIN_HEAD;
        else if (sts.last_bin)       state_nxt = S_FIN;
        else                         state_nxt = S_BIN_START;
      end
      S_BIN_HEAD: begin
        cmd.op    = goi_pkg::OP_BIN_HEAD;
        state_nxt = S_ENT_RD;
      end
      S_ENT_RD: begin
        cmd.op    = goi_pkg::OP_ENT_RD;
        state_nxt = S_ENT_VIS;
      end
      S_ENT_VIS: begin
        cmd.op    = goi_pkg::OP_ENT_VIS;
        state_nxt = S_ENT_UPD;
      end
      S_ENT_UPD: begin
        cmd.op    = goi_pkg::OP_ENT_UPD;
        state_nxt = sts.vis ? S_ENT_NEXT : S_NB_RD;
      end
      S_NB_RD: begin
        cmd.op    = goi_pkg::OP_NB_RD;
        state_nxt = sts.nb_ok ? S_NB_CHK : S_NB_NEXT;
      end
      S_NB_CHK: begin
        cmd.op    = goi_pkg::OP_NB_CHK;
        state_nxt = sts.nb_reject ? S_NB_NEXT : S_NB_SQ;
      end
      S_NB_SQ: begin
        cmd.op = goi_pkg::OP_NB_SQ;
        priority if (sts.sq_busy) begin
          state_nxt = S_NB_SQ;
        end else if (sts.push_ok) begin
          ret_nxt   = S_NB_NEXT;
          state_nxt = S_APP_RD;
        end else begin
          state_nxt = S_NB_NEXT;
        end
      end
      S_NB_NEXT: begin
        cmd.op    = goi_pkg::OP_NB_NEXT;
        state_nxt = sts.nb_last ? S_ENT_NEXT : S_NB_RD;
      end
      S_ENT_NEXT: begin
        cmd.op    = goi_pkg::OP_ENT_NEXT;
        state_nxt = S_ENT_ADV;
      end
      S_ENT_ADV: begin
        cmd.op = goi_pkg::OP_ENT_ADV;
        priority if (!sts.tail_hit) state_nxt = S_ENT_RD;
        else if (sts.last_bin)      state_nxt = S_FIN;
        else                        state_nxt = S_BIN_START;
      end
      S_FIN: begin
        cmd.op     = goi_pkg::OP_FIN;
        cmd.out_ld = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld)      out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_SCAN_RD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/grid_obstacle_inflation.sv
// ----------------------------------------------------------------------------
// grid_obstacle_inflation
// Bucketed wavefront obstacle inflation over an occupancy grid.
// ----------------------------------------------------------------------------
// Table and cell writes complete in the accept state; a cell read passes
// through a readout state for the registered grid memory read. A run
// transaction first sweeps every cell position, clearing the visit marks and
// queueing obstacle cells, then walks the distance bins: each queued entry is
// read, marked and updated, each neighbor in range waits for the square root
// unit before any append, and empty bins are skipped. No transaction is
// taken during a run; its result carries run_done. Reads of cells or table
// entries never written return undefined data.
`default_nettype none

module grid_obstacle_inflation #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int MAX_RADIUS  = 31,
  parameter int QUEUE_DEPTH = 131072
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire goi_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output goi_pkg::out_item_t                out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [goi_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [7:0] width_r, height_r;
  logic [4:0] radius_r;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= goi_pkg::GRID_WIDTH_RST;
      height_r <= goi_pkg::GRID_HEIGHT_RST;
      radius_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        goi_pkg::REG_GRID_WIDTH:  width_r  <= pwdata[7:0];
        goi_pkg::REG_GRID_HEIGHT: height_r <= pwdata[7:0];
        goi_pkg::REG_CELL_RADIUS: radius_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      goi_pkg::REG_GRID_WIDTH:  prdata = {24'd0, width_r};
      goi_pkg::REG_GRID_HEIGHT: prdata = {24'd0, height_r};
      goi_pkg::REG_CELL_RADIUS: prdata = {27'd0, radius_r};
      default:                  prdata = '0;
    endcase
  end

  goi_pkg::cmd_t cmd;
  goi_pkg::sts_t sts;

  goi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  goi_dpath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_RADIUS  (MAX_RADIUS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_data),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_radius (radius_r),
    .out_data   (out_data)
  );

  a_accept_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> cmd.op == goi_pkg::OP_ACCEPT)
    else $error("transaction taken without accept command");

  a_pool_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == goi_pkg::OP_APP_WR |-> !sts.pool_full)
    else $error("append into full entry pool");

  a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.sq_busy |-> cmd.op == goi_pkg::OP_NB_SQ)
    else $error("square root running outside its wait step");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_done |-> out_data.cell_value == '0)
    else $error("run result carries cell data");

endmodule

`default_nettype wire

### dv/grid_obstacle_inflation_tb.sv
// ----------------------------------------------------------------------------
// grid_obstacle_inflation_tb
// Self-checking bench for the obstacle inflation block. A queue-fed driver
// sends table loads, cell loads, runs and cell reads under random gaps; a
// monitor compares every result transaction with a predictor that repeats
// the bucketed wavefront in software. The grid size and radius are set over
// the APB port between idle phases.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_obstacle_inflation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW = 128;
  localparam int GH = 128;
  localparam int RMAX = 31;
  localparam int TSIDE = RMAX + 2;
  localparam int POOL_DEPTH = 131072;

  typedef struct {
    int x;
    int y;
    int sx;
    int sy;
  } wave_ent_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  goi_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  goi_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [goi_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  grid_obstacle_inflation uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic signed [7:0] grid_m [GW*GH];
  logic [6:0] cost_m [TSIDE*TSIDE];
  bit seen_m [GW*GH];
  wave_ent_t bin_q [2*TSIDE][$];
  int pool_cnt;
  int cfg_w = 128;
  int cfg_h = 128;
  int cfg_r = 0;

  // generator bookkeeping
  bit cell_def [GW*GH];
  bit cost_def [TSIDE*TSIDE];

  goi_pkg::in_item_t pend_items [$];
  goi_pkg::out_item_t cell_results_q [$];
  int mismatches = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_req = 0;

  function automatic int eff_w();
    return cfg_w > GW ? GW : cfg_w;
  endfunction

  function automatic int eff_h();
    return cfg_h > GH ? GH : cfg_h;
  endfunction

  function automatic int isqrt(int n);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic void wave_add(int b, int x, int y, int sx, int sy);
    wave_ent_t e;
    if (pool_cnt >= POOL_DEPTH) return;
    pool_cnt++;
    e.x = x; e.y = y; e.sx = sx; e.sy = sy;
    bin_q[b].insert(bin_q[b].size(), e);
  endfunction

  function automatic void wave_push(int x, int y, int sx, int sy, int cur, int r, int nb);
    int adx, ady, d2, b;
    if (seen_m[y*GW+x]) return;
    adx = x > sx ? x - sx : sx - x;
    ady = y > sy ? y - sy : sy - y;
    if (adx > r || ady > r) return;
    d2 = adx*adx + ady*ady;
    if (d2 > r*r) return;
    b = isqrt(4*d2);
    if (b < cur || b >= nb) return;
    wave_add(b, x, y, sx, sy);
  endfunction

  function automatic void inflate_grid();
    int w, h, r, nb, idx, adx, ady, cost;
    wave_ent_t e;
    w = eff_w(); h = eff_h();
    r = cfg_r > RMAX ? RMAX : cfg_r;
    nb = 2 * (r + 2);
    if (r == 0 || w == 0 || h == 0) return;
    foreach (seen_m[i]) seen_m[i] = 0;
    foreach (bin_q[i]) bin_q[i].delete();
    pool_cnt = 0;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        if (grid_m[y*GW+x] >= goi_pkg::OCCUPIED) wave_add(0, x, y, x, y);
    for (int b = 0; b < nb; b++) begin
      for (int i = 0; i < bin_q[b].size(); i++) begin
        e = bin_q[b][i];
        idx = e.y*GW + e.x;
        if (!seen_m[idx]) begin
          adx = e.x > e.sx ? e.x - e.sx : e.sx - e.x;
          ady = e.y > e.sy ? e.y - e.sy : e.sy - e.y;
          cost = cost_m[ady*TSIDE+adx];
          seen_m[idx] = 1;
          if (grid_m[idx] >= 0 && cost > int'(grid_m[idx])) grid_m[idx] = cost;
          if (e.x > 0) wave_push(e.x-1, e.y, e.sx, e.sy, b, r, nb);
          if (e.x + 1 < w) wave_push(e.x+1, e.y, e.sx, e.sy, b, r, nb);
          if (e.y > 0) wave_push(e.x, e.y-1, e.sx, e.sy, b, r, nb);
          if (e.y + 1 < h) wave_push(e.x, e.y+1, e.sx, e.sy, b, r, nb);
        end
      end
    end
  endfunction

  function automatic goi_pkg::out_item_t predict_item(goi_pkg::in_item_t it);
    goi_pkg::out_item_t o;
    int x, y;
    o = '0;
    x = it.cell_x; y = it.cell_y;
    case (it.mode)
      goi_pkg::MODE_TABLE: begin
        if (x < TSIDE && y < TSIDE) cost_m[y*TSIDE+x] = it.value[6:0];
      end
      goi_pkg::MODE_CELL: begin
        if (x < eff_w() && y < eff_h()) grid_m[y*GW+x] = it.value;
      end
      goi_pkg::MODE_RUN: begin
        inflate_grid();
        o.run_done = 1'b1;
      end
      default: begin
        if (x < eff_w() && y < eff_h()) o.cell_value = grid_m[y*GW+x];
      end
    endcase
    return o;
  endfunction

  function automatic int short_or_long();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall)
        cell_results_q.insert(cell_results_q.size(), predict_item(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_items.size() > 0) begin
          in_data <= pend_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
          end else begin
            gap_left = short_or_long();
            if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 80);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 99) < 15) stall_left = short_or_long();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    goi_pkg::out_item_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (cell_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", out_data);
      end else begin
        exp_o = cell_results_q.pop_front();
        if (out_data.cell_value !== exp_o.cell_value || out_data.run_done !== exp_o.run_done)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cell_value=%0d run_done=%0b got cell_value=%0d run_done=%0b",
                     exp_o.cell_value, exp_o.run_done, out_data.cell_value, out_data.run_done);
        end
      end
    end
  end

  function automatic goi_pkg::in_item_t mk(logic [1:0] m, int x, int y, int v);
    goi_pkg::in_item_t it;
    it.mode = m;
    it.cell_x = x[6:0];
    it.cell_y = y[6:0];
    it.value = v[7:0];
    if (m == goi_pkg::MODE_TABLE && x < TSIDE && y < TSIDE) cost_def[y*TSIDE+x] = 1;
    if (m == goi_pkg::MODE_CELL && x < eff_w() && y < eff_h()) cell_def[y*GW+x] = 1;
    return it;
  endfunction

  function automatic void enq(goi_pkg::in_item_t it);
    pend_items.insert(pend_items.size(), it);
  endfunction

  function automatic int cell_val();
    int p;
    p = $urandom_range(0, 99);
    if (p < 15) return $urandom_range(100, 127);
    if (p < 30) return -$urandom_range(1, 128);
    return $urandom_range(0, 99);
  endfunction

  function automatic int cost_val();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, 100);
  endfunction

  task automatic wait_idle();
    while (pend_items.size() > 0 || in_valid || cell_results_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, int v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= goi_pkg::CFG_AW'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      goi_pkg::REG_GRID_WIDTH: cfg_w = v & 8'hff;
      goi_pkg::REG_GRID_HEIGHT: cfg_h = v & 8'hff;
      default: cfg_r = v & 5'h1f;
    endcase
    @(negedge clk);
  endtask

  // every in-range cell and every reachable table entry gets written
  task automatic fill_defined();
    int tx, ty, r;
    r = cfg_r > RMAX ? RMAX : cfg_r;
    for (int y = 0; y < eff_h(); y++)
      for (int x = 0; x < eff_w(); x++)
        if (!cell_def[y*GW+x]) enq(mk(goi_pkg::MODE_CELL, x, y, cell_val()));
    tx = eff_w() - 1 < r ? eff_w() - 1 : r;
    ty = eff_h() - 1 < r ? eff_h() - 1 : r;
    for (int y = 0; y <= ty; y++)
      for (int x = 0; x <= tx; x++)
        if (!cost_def[y*TSIDE+x]) enq(mk(goi_pkg::MODE_TABLE, x, y, cost_val()));
  endtask

  function automatic int in_x();
    return eff_w() == 0 ? $urandom_range(0, 127) : $urandom_range(0, eff_w() - 1);
  endfunction

  function automatic int in_y();
    return eff_h() == 0 ? $urandom_range(0, 127) : $urandom_range(0, eff_h() - 1);
  endfunction

  task automatic run_and_read(int nreads);
    enq(mk(goi_pkg::MODE_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
           $urandom_range(0, 255)));
    for (int i = 0; i < nreads; i++)
      enq(mk(goi_pkg::MODE_READ, in_x(), in_y(), $urandom_range(0, 255)));
  endtask

  task automatic random_items(int n);
    int p, x, y;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      x = $urandom_range(0, 4) == 0 ? $urandom_range(0, 127) : in_x();
      y = $urandom_range(0, 4) == 0 ? $urandom_range(0, 127) : in_y();
      if (p < 45) begin
        enq(mk(goi_pkg::MODE_CELL, x, y, cell_val()));
      end else if (p < 80) begin
        enq(mk(goi_pkg::MODE_READ, x, y, $urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          x = $urandom_range(0, 127); y = $urandom_range(0, 127);
        end else begin
          x = $urandom_range(0, TSIDE - 1); y = $urandom_range(0, TSIDE - 1);
        end
        enq(mk(goi_pkg::MODE_TABLE, x, y, cost_val()));
      end
    end
  endtask

  int ph_w [9] = '{8, 1, 128, 255, 1, 0, 12, 6, 5};
  int ph_h [9] = '{8, 1, 1, 1, 128, 5, 10, 6, 9};
  int ph_r [9] = '{3, 31, 31, 9, 5, 3, 31, 0, 31};

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      cfg_write(goi_pkg::REG_GRID_WIDTH, ph_w[ph]);
      cfg_write(goi_pkg::REG_GRID_HEIGHT, ph_h[ph]);
      if (ph == 0) begin
        enq(mk(goi_pkg::MODE_RUN, 0, 0, 0));  // radius still zero
        wait_idle();
      end
      cfg_write(goi_pkg::REG_CELL_RADIUS, ph_r[ph]);
      if (ph == 0) begin
        fill_defined();
        enq(mk(goi_pkg::MODE_TABLE, 127, 127, 55));
        enq(mk(goi_pkg::MODE_TABLE, 33, 0, 55));
        enq(mk(goi_pkg::MODE_TABLE, 0, 33, 55));
        enq(mk(goi_pkg::MODE_TABLE, 32, 32, -128));
        enq(mk(goi_pkg::MODE_TABLE, 32, 0, 127));
        enq(mk(goi_pkg::MODE_TABLE, 2, 1, 127));
        enq(mk(goi_pkg::MODE_TABLE, 1, 1, -1));
        enq(mk(goi_pkg::MODE_CELL, 0, 0, 100));
        enq(mk(goi_pkg::MODE_CELL, 7, 7, 127));
        enq(mk(goi_pkg::MODE_CELL, 1, 0, -128));
        enq(mk(goi_pkg::MODE_CELL, 0, 1, -1));
        enq(mk(goi_pkg::MODE_CELL, 3, 3, 99));
        enq(mk(goi_pkg::MODE_CELL, 6, 7, 0));
        enq(mk(goi_pkg::MODE_CELL, 127, 127, 100));
        enq(mk(goi_pkg::MODE_CELL, 8, 0, 100));
        enq(mk(goi_pkg::MODE_READ, 127, 127, 0));
        enq(mk(goi_pkg::MODE_READ, 0, 8, 0));
        enq(mk(goi_pkg::MODE_READ, 7, 7, 0));
        enq(mk(goi_pkg::MODE_RUN, 127, 127, -1));
        for (int y = 0; y < 8; y++) enq(mk(goi_pkg::MODE_READ, y, y, 0));
        enq(mk(goi_pkg::MODE_READ, 1, 0, 0));
        enq(mk(goi_pkg::MODE_READ, 0, 1, 0));
      end
      fill_defined();
      if (ph == 2) hold_req = 1;
      random_items(60);
      run_and_read(20);
      // sender pauses until the block has drained
      wait_idle();
      random_items(30);
      run_and_read(20);
    end
    wait_idle();
    cfg_write(goi_pkg::REG_GRID_WIDTH, 128);
    cfg_write(goi_pkg::REG_GRID_HEIGHT, 128);
    repeat (100) @(negedge clk);
    if (mismatches == 0 && cell_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hdl/goi_pkg.sv
hdl/goi_isqrt.sv
hdl/goi_dpath.sv
hdl/goi_ctrl.sv
hdl/grid_obstacle_inflation.sv
dv/grid_obstacle_inflation_tb.sv
